[rtl/button_click_classifier_macros.svh]
// Assertion macros for the button click classifier.
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// Same-cycle implication, clocked on clk_i, quiet during reset.
`define BCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("button_click_classifier: same-cycle check failed");

// Next-cycle implication, clocked on clk_i, quiet during reset.
`define BCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("button_click_classifier: next-cycle check failed");

`endif

[rtl/bcc_pkg.sv]
// Types and constants shared by the button click classifier files.
`timescale 1ns / 1ps

package bcc_pkg;

  localparam int unsigned DbWidth  = 10;
  localparam int unsigned TmWidth  = 16;
  localparam int unsigned CntWidth = 16;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] CfgDebounce = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgLong     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgStuck    = 2'd2;

  localparam logic [DbWidth-1:0] DebounceReset = 10'd30;
  localparam logic [TmWidth-1:0] LongReset     = 16'd2000;
  localparam logic [TmWidth-1:0] StuckReset    = 16'd10000;

  localparam logic [DbWidth-1:0] DbMax = {DbWidth{1'b1}};
  localparam logic [TmWidth-1:0] TmMax = {TmWidth{1'b1}};

  typedef struct packed {
    logic [DbWidth-1:0] debounce_ticks;
    logic [TmWidth-1:0] long_click_ticks;
    logic [TmWidth-1:0] stuck_ticks;
  } cfg_t;

  typedef struct packed {
    logic                stable_level;
    logic                previous_stable;
    logic                candidate_level;
    logic [DbWidth-1:0]  debounce_timer;
    logic                debounce_active;
    logic [TmWidth-1:0]  long_timer;
    logic                long_armed;
    logic [TmWidth-1:0]  stuck_timer;
    logic                stuck_armed;
    logic [CntWidth-1:0] short_counter;
    logic [CntWidth-1:0] long_counter;
    logic                fault_flag;
  } state_t;

  typedef struct packed {
    logic                stable_pressed;
    logic                short_click;
    logic                long_click;
    logic                stuck_event;
    logic                stuck_latched;
    logic [CntWidth-1:0] short_total;
    logic [CntWidth-1:0] long_total;
  } result_t;

endpackage

[rtl/button_click_classifier.sv]
// Path: an accepted pin sample waits in the input register, then moves to the result register
// when that slot frees. Throughput: one item per cycle while the output is not stalled;
// the input register takes one more item while a result waits. Rate is set by the
// combinational path through the debounce, timer and compare logic.
// Reset (rst_ni low, asynchronous): the settings return to their reset values, state clears
// to not pressed with timers stopped and counters zero, both stages empty.
`timescale 1ns / 1ps

module button_click_classifier import bcc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    pin_level_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    stable_pressed_o,
  output logic                    short_click_o,
  output logic                    long_click_o,
  output logic                    stuck_event_o,
  output logic                    stuck_latched_o,
  output logic [CntWidth-1:0]     short_total_o,
  output logic [CntWidth-1:0]     long_total_o
);

  `include "button_click_classifier_macros.svh"

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    inq_valid_q;
  logic    pin_q;
  logic    out_valid_q;
  logic    advance;

  // move the held item into the result register when that slot frees
  assign advance    = inq_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !inq_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DebounceReset;
      cfg_q.long_click_ticks <= LongReset;
      cfg_q.stuck_ticks      <= StuckReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDebounce: cfg_q.debounce_ticks   <= cfg_wdata_i[DbWidth-1:0];
        CfgLong:     cfg_q.long_click_ticks <= cfg_wdata_i[TmWidth-1:0];
        CfgStuck:    cfg_q.stuck_ticks      <= cfg_wdata_i[TmWidth-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  bcc_step u_step (
    .st_i        (state_q),
    .cfg_i       (cfg_q),
    .pin_level_i (pin_q),
    .st_o        (state_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      inq_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        inq_valid_q <= 1'b1;
      end else if (advance) begin
        inq_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pin_q <= pin_level_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stable_pressed_o = res_q.stable_pressed;
  assign short_click_o    = res_q.short_click;
  assign long_click_o     = res_q.long_click;
  assign stuck_event_o    = res_q.stuck_event;
  assign stuck_latched_o  = res_q.stuck_latched;
  assign short_total_o    = res_q.short_total;
  assign long_total_o     = res_q.long_total;

  `BCC_ASSERT_NOW(a_click_exclusive, out_valid_q, !(res_q.short_click && res_q.long_click))
  `BCC_ASSERT_NOW(a_stuck_sets_flag, out_valid_q && res_q.stuck_event, res_q.stuck_latched && res_q.stable_pressed)
  `BCC_ASSERT_NEXT(a_fault_sticky, state_q.fault_flag, state_q.fault_flag)
  `BCC_ASSERT_NEXT(a_short_count, advance && res_d.short_click, state_q.short_counter == $past(state_q.short_counter) + 16'd1)

endmodule

[rtl/bcc_step.sv]
// Next-state and result logic for one pin sample.
`timescale 1ns / 1ps

module bcc_step import bcc_pkg::*; (
  input  state_t  st_i,
  input  cfg_t    cfg_i,
  input  logic    pin_level_i,
  output state_t  st_o,
  output result_t res_o
);

  always_comb begin
    state_t s;
    logic   raw;
    logic   press_edge;
    logic   release_edge;
    logic   short_p;
    logic   long_p;
    logic   stuck_p;

    s            = st_i;
    raw          = ~pin_level_i;
    press_edge   = 1'b0;
    release_edge = 1'b0;
    short_p      = 1'b0;
    long_p       = 1'b0;
    stuck_p      = 1'b0;

    // debounce
    if (raw == s.stable_level) begin
      s.candidate_level = s.stable_level;
      s.debounce_active = 1'b0;
      s.debounce_timer  = '0;
    end else begin
      if (!s.debounce_active || (s.candidate_level != raw)) begin
        s.candidate_level = raw;
        s.debounce_active = 1'b1;
        s.debounce_timer  = {{(DbWidth-1){1'b0}}, 1'b1};
      end else if (s.debounce_timer != DbMax) begin
        s.debounce_timer = s.debounce_timer + 1'b1;
      end
      if (s.debounce_timer >= cfg_i.debounce_ticks) begin
        s.previous_stable = s.stable_level;
        s.stable_level    = s.candidate_level;
        s.debounce_active = 1'b0;
        s.debounce_timer  = '0;
        if (!s.previous_stable && s.stable_level) begin
          press_edge = 1'b1;
        end else if (s.previous_stable && !s.stable_level) begin
          release_edge = 1'b1;
        end
      end
    end

    // arm on press, classify on release, otherwise advance the timers
    if (press_edge) begin
      s.long_armed  = 1'b1;
      s.long_timer  = '0;
      s.stuck_armed = 1'b1;
      s.stuck_timer = '0;
    end else if (release_edge) begin
      if (s.long_armed) begin
        short_p         = 1'b1;
        s.short_counter = s.short_counter + 1'b1;
      end
      s.long_armed  = 1'b0;
      s.long_timer  = '0;
      s.stuck_armed = 1'b0;
      s.stuck_timer = '0;
    end else begin
      if (s.long_armed && (s.long_timer != TmMax)) begin
        s.long_timer = s.long_timer + 1'b1;
      end
      if (s.stuck_armed && (s.stuck_timer != TmMax)) begin
        s.stuck_timer = s.stuck_timer + 1'b1;
      end
    end

    if (s.long_armed && (s.long_timer >= cfg_i.long_click_ticks)) begin
      long_p         = 1'b1;
      s.long_armed   = 1'b0;
      s.long_timer   = '0;
      s.long_counter = s.long_counter + 1'b1;
    end

    if (s.stuck_armed && s.stable_level && (s.stuck_timer >= cfg_i.stuck_ticks)) begin
      stuck_p       = 1'b1;
      s.stuck_armed = 1'b0;
      s.stuck_timer = '0;
      s.fault_flag  = 1'b1;
    end

    st_o                 = s;
    res_o.stable_pressed = s.stable_level;
    res_o.short_click    = short_p;
    res_o.long_click     = long_p;
    res_o.stuck_event    = stuck_p;
    res_o.stuck_latched  = s.fault_flag;
    res_o.short_total    = s.short_counter;
    res_o.long_total     = s.long_counter;
  end

endmodule

[bench/testbench.sv]
// Self-checking testbench for the button click classifier.
`timescale 1ns / 1ps

module testbench;
  import bcc_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned IdlePct       = 77;
  localparam int unsigned BothIdlePct   = 19;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned PhaseItems    = 160;
  localparam int unsigned PressurePhase = 4;

  // Index past the end of the register list; writes to it are ignored.
  localparam logic [CfgIdxWidth-1:0] CfgUnused = 2'd3;

  typedef enum logic [0:0] {
    RowTick,
    RowReg
  } row_kind_e;

  typedef enum logic [1:0] {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CfgIdxWidth-1:0]  reg_idx;
    logic [CfgDataWidth-1:0] reg_data;
    logic                    pin;
    logic                    typed;
    result_t                 res;
  } stim_row_t;

  function automatic stim_row_t reg_row(logic [CfgIdxWidth-1:0] idx,
                                        logic [CfgDataWidth-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind     = RowReg;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic stim_row_t tick_row(logic pin);
    stim_row_t row;
    row = '0;
    row.kind = RowTick;
    row.pin  = pin;
    return row;
  endfunction

  function automatic stim_row_t checked_row(logic pin, result_t res);
    stim_row_t row;
    row = tick_row(pin);
    row.typed = 1'b1;
    row.res   = res;
    return row;
  endfunction

  localparam int unsigned NumRows = 36;

  // Pin level 0 means pressed.
  localparam stim_row_t DirectedRows [NumRows] = '{
    // reset settings: released pin, then a single-tick bounce
    checked_row(1'b1, result_t'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}),
    checked_row(1'b0, result_t'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}),
    tick_row(1'b1),
    reg_row(CfgUnused, 16'hFFFF),
    reg_row(CfgDebounce, 16'hFFFF),
    tick_row(1'b0),
    tick_row(1'b1),
    // zero thresholds: press, long click and stuck fault all on the first tick
    reg_row(CfgDebounce, 16'h0000),
    reg_row(CfgLong, 16'h0000),
    reg_row(CfgStuck, 16'h0000),
    checked_row(1'b0, result_t'{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0, 16'd1}),
    tick_row(1'b0),
    checked_row(1'b1, result_t'{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 16'd1}),
    // bounce, short click, then long click followed by stuck fault
    reg_row(CfgDebounce, 16'd2),
    reg_row(CfgLong, 16'd3),
    reg_row(CfgStuck, 16'd4),
    tick_row(1'b0),
    tick_row(1'b1),
    tick_row(1'b0),
    tick_row(1'b0),
    tick_row(1'b0),
    tick_row(1'b1),
    tick_row(1'b1),
    tick_row(1'b0),
    tick_row(1'b0),
    tick_row(1'b0),
    tick_row(1'b0),
    tick_row(1'b0),
    tick_row(1'b0),
    tick_row(1'b1),
    tick_row(1'b1),
    // widest timers
    reg_row(CfgDebounce, 16'd1),
    reg_row(CfgLong, 16'hFFFF),
    reg_row(CfgStuck, 16'hFFFF),
    tick_row(1'b0),
    tick_row(1'b1)
  };

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i   = '0;
  logic [CfgDataWidth-1:0] cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic                    pin_level_i = 1'b1;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    stable_pressed_o;
  logic                    short_click_o;
  logic                    long_click_o;
  logic                    stuck_event_o;
  logic                    stuck_latched_o;
  logic [CntWidth-1:0]     short_total_o;
  logic [CntWidth-1:0]     long_total_o;

  button_click_classifier i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .pin_level_i,
    .out_valid_o,
    .out_ready_i,
    .stable_pressed_o,
    .short_click_o,
    .long_click_o,
    .stuck_event_o,
    .stuck_latched_o,
    .short_total_o,
    .long_total_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted button state and settings
  cfg_t                click_cfg;
  logic                pressed_now;
  logic                cand_level;
  logic                db_running;
  logic [DbWidth-1:0]  db_count;
  logic                long_run;
  logic [TmWidth-1:0]  long_count;
  logic                stuck_run;
  logic [TmWidth-1:0]  stuck_count;
  logic [CntWidth-1:0] short_clicks;
  logic [CntWidth-1:0] long_clicks;
  logic                fault_seen;

  result_t     pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  int unsigned hold_left      = 0;
  bit          hold_off_req   = 1'b0;

  function automatic result_t classify_tick(logic pin);
    result_t r;
    logic    raw;
    logic    was_pressed;
    logic    press_edge;
    logic    release_edge;
    r            = '0;
    raw          = ~pin;
    press_edge   = 1'b0;
    release_edge = 1'b0;
    if (raw == pressed_now) begin
      cand_level = pressed_now;
      db_running = 1'b0;
      db_count   = '0;
    end else begin
      if (!db_running || cand_level != raw) begin
        cand_level = raw;
        db_running = 1'b1;
        db_count   = DbWidth'(1);
      end else if (db_count != DbMax) begin
        db_count++;
      end
      if (db_count >= click_cfg.debounce_ticks) begin
        was_pressed  = pressed_now;
        pressed_now  = cand_level;
        db_running   = 1'b0;
        db_count     = '0;
        press_edge   = !was_pressed && pressed_now;
        release_edge = was_pressed && !pressed_now;
      end
    end

    if (press_edge) begin
      long_run    = 1'b1;
      long_count  = '0;
      stuck_run   = 1'b1;
      stuck_count = '0;
    end else if (release_edge) begin
      // a release only counts as a short click while no long click has fired
      if (long_run) begin
        r.short_click = 1'b1;
        short_clicks++;
      end
      long_run    = 1'b0;
      long_count  = '0;
      stuck_run   = 1'b0;
      stuck_count = '0;
    end else begin
      if (long_run && long_count != TmMax) long_count++;
      if (stuck_run && stuck_count != TmMax) stuck_count++;
    end

    if (long_run && long_count >= click_cfg.long_click_ticks) begin
      r.long_click = 1'b1;
      long_run     = 1'b0;
      long_count   = '0;
      long_clicks++;
    end
    if (stuck_run && pressed_now && stuck_count >= click_cfg.stuck_ticks) begin
      r.stuck_event = 1'b1;
      stuck_run     = 1'b0;
      stuck_count   = '0;
      fault_seen    = 1'b1;
    end

    r.stable_pressed = pressed_now;
    r.stuck_latched  = fault_seen;
    r.short_total    = short_clicks;
    r.long_total     = long_clicks;
    return r;
  endfunction

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CfgDebounce: click_cfg.debounce_ticks   = data[DbWidth-1:0];
      CfgLong:     click_cfg.long_click_ticks = data[TmWidth-1:0];
      CfgStuck:    click_cfg.stuck_ticks      = data[TmWidth-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pin(logic pin, bit typed = 1'b0, result_t typed_res = '0);
    result_t predicted;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pin_level_i <= pin;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = classify_tick(pin);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid and hold until every result is back, then idle before returning.
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_left    = HoldOffCycles;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = result_t'{stable_pressed_o, short_click_o, long_click_o, stuck_event_o,
                        stuck_latched_o, short_total_o, long_total_o};
        if (pending_results.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("result %0d arrived with nothing pending", results_seen);
          end
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("result %0d: expected pressed=%0b short=%0b long=%0b stuck=%0b",
                       results_seen, want.stable_pressed, want.short_click,
                       want.long_click, want.stuck_event);
              $display("  latched=%0b short_total=%0d long_total=%0d",
                       want.stuck_latched, want.short_total, want.long_total);
              $display("  got pressed=%0b short=%0b long=%0b stuck=%0b",
                       got.stable_pressed, got.short_click, got.long_click,
                       got.stuck_event);
              $display("  latched=%0b short_total=%0d long_total=%0d",
                       got.stuck_latched, got.short_total, got.long_total);
            end
            mismatch_count++;
          end
        end
        results_seen++;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no item moved for %0d cycles", WatchdogLimit);
        $display("** button_click_classifier: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned hold;
    int unsigned rel;
    int unsigned db_v;
    int unsigned long_v;
    int unsigned stuck_v;
    int unsigned phase_len;
    idle_mode_e  mode;

    click_cfg    = '{DebounceReset, LongReset, StuckReset};
    pressed_now  = 1'b0;
    cand_level   = 1'b0;
    db_running   = 1'b0;
    db_count     = '0;
    long_run     = 1'b0;
    long_count   = '0;
    stuck_run    = 1'b0;
    stuck_count  = '0;
    short_clicks = '0;
    long_clicks  = '0;
    fault_seen   = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      if (DirectedRows[r].kind == RowReg) begin
        wait_until_idle();
        write_reg(DirectedRows[r].reg_idx, DirectedRows[r].reg_data);
      end else begin
        send_pin(DirectedRows[r].pin, DirectedRows[r].typed, DirectedRows[r].res);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_until_idle();
      phase_len = PhaseItems;
      if (p == 0) begin
        db_v = 0; long_v = 0; stuck_v = 0;
      end else if (p == 1) begin
        db_v = 1; long_v = 1; stuck_v = 1;
      end else if (p == NumPhases - 1) begin
        db_v = DbMax; long_v = TmMax; stuck_v = TmMax;
        phase_len = 40;
      end else begin
        db_v    = $urandom_range(0, 6);
        long_v  = $urandom_range(0, 40);
        stuck_v = $urandom_range(0, 90);
      end
      // upper data bits beyond the debounce field are random and must be dropped
      write_reg(CfgDebounce, CfgDataWidth'(($urandom_range(63) << DbWidth) | db_v));
      write_reg(CfgLong, CfgDataWidth'(long_v));
      write_reg(CfgStuck, CfgDataWidth'(stuck_v));
      write_reg(CfgUnused, CfgDataWidth'($urandom_range(16'hFFFF)));

      mode = idle_mode_e'(p % 4);
      if (p == PressurePhase) mode = IdleNone;
      tx_idle_pct  = (mode == IdleSender)   ? IdlePct :
                     (mode == IdleBoth)     ? BothIdlePct : 0;
      rx_stall_pct = (mode == IdleReceiver) ? IdlePct :
                     (mode == IdleBoth)     ? BothIdlePct : 0;
      if (p == PressurePhase) hold_off_req = 1'b1;

      sent = 0;
      while (sent < phase_len) begin
        if ($urandom_range(9) == 0) begin
          n = $urandom_range(1, 8);
          repeat (n) send_pin(1'($urandom_range(1)));
          sent += n;
        end else begin
          // bounce, hold pressed, bounce, hold released
          n = $urandom_range(0, 3);
          for (int j = 0; j < n; j++) send_pin(1'(j % 2));
          hold = $urandom_range(1, (db_v + stuck_v + 8 > 120) ? 120 : db_v + stuck_v + 8);
          repeat (hold) send_pin(1'b0);
          rel = $urandom_range(0, 3);
          for (int j = 0; j < rel; j++) send_pin(1'((j + 1) % 2));
          sent += n + hold + rel;
          hold = $urandom_range(1, (db_v + 8 > 60) ? 60 : db_v + 8);
          repeat (hold) send_pin(1'b1);
          sent += hold;
        end
      end
    end

    wait_until_idle();
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** button_click_classifier: PASSED **");
    end else begin
      $display("** button_click_classifier: FAILED **");
    end
    $finish;
  end

endmodule
